// ===== rtl/sact_pkg.sv =====
// ----------------------------------------------------------------------------
// sact_pkg - shared types for the set-associative cache tag controller
// Transaction payloads, stored line layout, command codes, register indexes.
// ----------------------------------------------------------------------------
package sact_pkg;

  localparam logic CMD_LOOKUP  = 1'b0;
  localparam logic CMD_INSTALL = 1'b1;

  localparam logic [1:0] POL_LRU  = 2'd0;
  localparam logic [1:0] POL_LFU  = 2'd1;
  localparam logic [1:0] POL_PART = 2'd2;
  localparam logic [1:0] POL_RSVD = 2'd3;

  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_QUOTA  = 1'b1;

  localparam logic [5:0] FREQ_MAX = 6'd63;
  localparam int         USE_W    = 5;

  typedef struct packed {
    logic        cmd;
    logic [31:0] line_addr;
    logic        write_op;
    logic [1:0]  core_id;
    logic [31:0] timestamp;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  victim_way;
    logic        evicted_valid;
    logic        evicted_dirty;
    logic [31:0] evicted_tag;
    logic [1:0]  evicted_core;
    logic [31:0] read_accesses;
    logic [31:0] read_misses;
    logic [31:0] write_accesses;
    logic [31:0] write_misses;
    logic [31:0] dirty_evictions;
  } rsp_t;

  typedef struct packed {
    logic        valid;
    logic        dirty;
    logic [31:0] tag;
    logic [5:0]  freq;
    logic [31:0] stamp;
    logic [1:0]  owner;
  } line_t;

  localparam int LINE_W = $bits(line_t);

  typedef struct packed {
    logic [1:0] policy;
    logic [3:0] quota;
  } cfg_t;

endpackage

// ===== rtl/sact_ram.sv =====
// ----------------------------------------------------------------------------
// sact_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sact_front.sv =====
// ----------------------------------------------------------------------------
// sact_front - request intake
// Two-entry queue that takes request transactions and holds them for the
// back end, so intake and processing stall independently.
// ----------------------------------------------------------------------------
module sact_front
  import sact_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  output logic full,
  input  req_t req,
  output logic head_valid,
  output req_t head,
  input  logic head_pop
);

  req_t       slot [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign full       = (count == 2'd2);
  assign head_valid = (count != 2'd0);
  assign head       = slot[rptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      slot[wptr] <= req;
    end
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push && !full) begin
        wptr <= ~wptr;
      end
      if (head_pop && head_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'((push && !full) ? 1 : 0) - 2'((head_pop && head_valid) ? 1 : 0);
    end
  end

endmodule

// ===== rtl/sact_back.sv =====
// ----------------------------------------------------------------------------
// sact_back - tag store engine
// Reads one set row, resolves a lookup in parallel or scans the ways one per
// cycle for an install victim, writes the row back and issues the response.
// ----------------------------------------------------------------------------
module sact_back
  import sact_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input  logic clk,
  input  logic rst,
  input  cfg_t cfg,
  input  logic head_valid,
  input  req_t head,
  output logic head_pop,
  output logic empty,
  input  logic pop,
  output rsp_t rsp
);

  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W = WAYS * LINE_W;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_READ  = 5'b00100,
    S_SCAN  = 5'b01000,
    S_WRITE = 5'b10000
  } state_t;

  state_t state;

  function automatic logic [SET_W-1:0] set_of(input logic [31:0] addr);
    return (SETS > 1) ? SET_W'(addr) : '0;
  endfunction

  req_t             cur;
  line_t [WAYS-1:0] row;
  logic [ROW_W-1:0] ram_q;
  logic             ram_we;
  logic [SET_W-1:0] ram_waddr;
  logic [ROW_W-1:0] ram_wdata;
  logic [SET_W-1:0] clr_idx;

  // scan state
  logic [WAY_W-1:0] way_idx;
  logic             inv_found;
  logic [WAY_W-1:0] inv_way;
  logic [WAY_W-1:0] lru_way;
  logic [31:0]      lru_stamp;
  logic [WAY_W-1:0] bst_way;
  logic [5:0]       bst_freq;
  logic [31:0]      bst_stamp;
  logic             own_have;
  logic [WAY_W-1:0] own_way;
  logic [5:0]       own_freq;
  logic [31:0]      own_stamp;
  logic [USE_W-1:0] usage;

  logic [31:0] rd_acc, rd_miss, wr_acc, wr_miss, dirty_ev;
  logic        out_valid;

  sact_ram #(.WIDTH(ROW_W), .DEPTH(SETS), .AW(SET_W)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (set_of(head.line_addr)),
    .rdata (ram_q)
  );

  line_t scan_line;
  assign scan_line = row[way_idx];

  // victim choice once the scan is done
  logic [WAY_W-1:0] pol_way;
  logic [WAY_W-1:0] victim;
  logic [USE_W-1:0] quota_x;

  assign quota_x = USE_W'(cfg.quota);

  always_comb begin
    pol_way = '0;
    unique case (cfg.policy)
      POL_LRU: pol_way = lru_way;
      POL_LFU: pol_way = bst_way;
      POL_PART: begin
        if (usage > quota_x) begin
          pol_way = (cur.core_id == 2'd0) ? own_way : bst_way;
        end else if (usage < quota_x) begin
          pol_way = (cur.core_id == 2'd0) ? bst_way : own_way;
        end else begin
          pol_way = own_way;
        end
      end
      default: pol_way = '0;
    endcase
    if (WAYS == 1) begin
      victim = '0;
    end else if (inv_found) begin
      victim = inv_way;
    end else begin
      victim = pol_way;
    end
  end

  // row update and response
  line_t [WAYS-1:0] new_row;
  logic             hit;
  line_t            old_line;
  rsp_t             rsp_next;
  logic [31:0]      rd_acc_next, rd_miss_next, wr_acc_next, wr_miss_next, dirty_ev_next;
  logic             fire;

  always_comb begin
    new_row  = row;
    hit      = 1'b0;
    old_line = row[victim];
    rd_acc_next   = rd_acc;
    rd_miss_next  = rd_miss;
    wr_acc_next   = wr_acc;
    wr_miss_next  = wr_miss;
    dirty_ev_next = dirty_ev;
    if (cur.cmd == CMD_LOOKUP) begin
      for (int w = 0; w < WAYS; w++) begin
        if (row[w].valid && row[w].tag == cur.line_addr) begin
          hit = 1'b1;
          if (row[w].freq < FREQ_MAX) begin
            new_row[w].freq = row[w].freq + 6'd1;
          end
          new_row[w].stamp = cur.timestamp;
          if (cur.write_op) begin
            new_row[w].dirty = 1'b1;
          end
        end
      end
      if (cur.write_op) begin
        wr_acc_next  = wr_acc + 32'd1;
        wr_miss_next = wr_miss + 32'(!hit);
      end else begin
        rd_acc_next  = rd_acc + 32'd1;
        rd_miss_next = rd_miss + 32'(!hit);
      end
    end else begin
      new_row[victim] = '{valid: 1'b1, dirty: cur.write_op, tag: cur.line_addr,
                          freq: 6'd1, stamp: cur.timestamp, owner: cur.core_id};
      dirty_ev_next = dirty_ev + 32'(old_line.valid && old_line.dirty);
    end
    rsp_next.hit             = hit;
    rsp_next.victim_way      = (cur.cmd == CMD_INSTALL) ? 3'(victim) : 3'd0;
    rsp_next.evicted_valid   = (cur.cmd == CMD_INSTALL) && old_line.valid;
    rsp_next.evicted_dirty   = (cur.cmd == CMD_INSTALL) && old_line.dirty;
    rsp_next.evicted_tag     = (cur.cmd == CMD_INSTALL) ? old_line.tag : 32'd0;
    rsp_next.evicted_core    = (cur.cmd == CMD_INSTALL) ? old_line.owner : 2'd0;
    rsp_next.read_accesses   = rd_acc_next;
    rsp_next.read_misses     = rd_miss_next;
    rsp_next.write_accesses  = wr_acc_next;
    rsp_next.write_misses    = wr_miss_next;
    rsp_next.dirty_evictions = dirty_ev_next;
  end

  assign fire     = (state == S_WRITE) && (!out_valid || pop);
  assign head_pop = (state == S_IDLE) && head_valid;
  assign empty    = !out_valid;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = set_of(cur.line_addr);
    ram_wdata = new_row;
    if (state == S_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_idx;
      ram_wdata = '0;
    end else if (fire) begin
      ram_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (head_pop) begin
      cur <= head;
    end
    if (state == S_READ) begin
      row       <= ram_q;
      way_idx   <= '0;
      inv_found <= 1'b0;
      inv_way   <= '0;
      lru_way   <= '0;
      bst_way   <= '0;
      own_have  <= 1'b0;
      own_way   <= '0;
      usage     <= '0;
    end
    if (state == S_SCAN) begin
      way_idx <= way_idx + WAY_W'(1);
      if (!inv_found && !scan_line.valid) begin
        inv_found <= 1'b1;
        inv_way   <= way_idx;
      end
      if (way_idx == '0 || scan_line.stamp < lru_stamp) begin
        lru_way   <= way_idx;
        lru_stamp <= scan_line.stamp;
      end
      if (way_idx == '0 || scan_line.freq < bst_freq ||
          (scan_line.freq == bst_freq && scan_line.stamp > bst_stamp)) begin
        bst_way   <= way_idx;
        bst_freq  <= scan_line.freq;
        bst_stamp <= scan_line.stamp;
      end
      if (scan_line.owner == cur.core_id &&
          (!own_have || scan_line.freq < own_freq ||
           (scan_line.freq == own_freq && scan_line.stamp > own_stamp))) begin
        own_have  <= 1'b1;
        own_way   <= way_idx;
        own_freq  <= scan_line.freq;
        own_stamp <= scan_line.stamp;
      end
      if (scan_line.owner == 2'd0) begin
        usage <= usage + USE_W'(1);
      end
    end
    if (fire) begin
      rsp <= rsp_next;
    end
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      out_valid <= 1'b0;
      rd_acc    <= '0;
      rd_miss   <= '0;
      wr_acc    <= '0;
      wr_miss   <= '0;
      dirty_ev  <= '0;
    end else begin
      if (fire) begin
        out_valid <= 1'b1;
        rd_acc    <= rd_acc_next;
        rd_miss   <= rd_miss_next;
        wr_acc    <= wr_acc_next;
        wr_miss   <= wr_miss_next;
        dirty_ev  <= dirty_ev_next;
      end else if (pop && out_valid) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + SET_W'(1);
          if (clr_idx == SET_W'(SETS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (head_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= (cur.cmd == CMD_INSTALL) ? S_SCAN : S_WRITE;
        end
        S_SCAN: begin
          if (way_idx == WAY_W'(WAYS - 1)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (fire) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/set_assoc_cache_tag_controller.sv =====
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_controller - tag store with LRU / LFU / partitioning
//
//   channel  | handshake      | payload
//   ---------+----------------+----------------------------
//   request  | push / full    | req (cmd, line_addr, ...)
//   response | pop / empty    | rsp (hit, victim, counters)
//   config   | APB psel/pen.. | policy @0x0, core0_quota @0x4
//
// A lookup goes through set read, data capture and write-back in the engine;
// an install adds a victim scan before write-back, visiting one way per cycle.
// After reset a clearing pass writes every set of the RAM, one set per cycle;
// requests queue up (two entries) but are not processed until it ends.
// The response register holds a result until popped; the engine stalls in
// write-back while it is occupied.
// ----------------------------------------------------------------------------
module set_assoc_cache_tag_controller
  import sact_pkg::*;
#(
  parameter int SETS = 256,
  parameter int WAYS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  req_t        req,
  output logic        empty,
  input  logic        pop,
  output rsp_t        rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  cfg_t cfg;
  logic head_valid;
  req_t head;
  logic head_pop;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_QUOTA) ? {28'd0, cfg.quota} : {30'd0, cfg.policy};

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.policy <= POL_LRU;
      cfg.quota  <= 4'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == REG_POLICY) begin
        cfg.policy <= pwdata[1:0];
      end else begin
        cfg.quota <= pwdata[3:0];
      end
    end
  end

  sact_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop)
  );

  sact_back #(.SETS(SETS), .WAYS(WAYS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head       (head),
    .head_pop   (head_pop),
    .empty      (empty),
    .pop        (pop),
    .rsp        (rsp)
  );

endmodule

// ===== rtl/sact_checker.sv =====
// ----------------------------------------------------------------------------
// sact_checker - port-level checks for the tag controller
// Watches the top-level ports only; attached by bind.
// ----------------------------------------------------------------------------
module sact_checker
  import sact_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic empty,
  input logic pop,
  input rsp_t rsp,
  input logic pready
);

  // a response waiting and not taken stays put
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    !empty && !pop |=> !empty && $stable(rsp))
    else $error("response changed while stalled");

  // lookup hits report no victim
  a_lookup_clean: assert property (@(posedge clk) disable iff (rst)
    !empty && rsp.hit |-> rsp.victim_way == 3'd0 && !rsp.evicted_valid)
    else $error("hit response carries eviction data");

  // nothing can come out during the first cycle after reset
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> empty)
    else $error("response visible right after reset");

  // a hit carries no evicted line contents at all
  a_hit_no_evict_data: assert property (@(posedge clk) disable iff (rst)
    !empty && rsp.hit |-> !rsp.evicted_dirty && rsp.evicted_tag == 32'd0 &&
                          rsp.evicted_core == 2'd0)
    else $error("hit response carries evicted line fields");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready dropped");

endmodule

bind set_assoc_cache_tag_controller sact_checker u_sact_checker (
  .clk    (clk),
  .rst    (rst),
  .empty  (empty),
  .pop    (pop),
  .rsp    (rsp),
  .pready (pready)
);
